[rtl/dlp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dlp_pkg
// shared constants, types and helper functions of the distance line parser
// ----------------------------------------------------------------------------
package dlp_pkg;

    localparam int LINE_CAPACITY_DEF = 128;

    localparam logic [2:0] PH_LEAD   = 3'd0;
    localparam logic [2:0] PH_DIGITS = 3'd1;
    localparam logic [2:0] PH_GAP    = 3'd2;
    localparam logic [2:0] PH_C      = 3'd3;
    localparam logic [2:0] PH_M      = 3'd4;
    localparam logic [2:0] PH_TAIL   = 3'd5;
    localparam logic [2:0] PH_FAIL   = 3'd6;

    localparam logic [1:0] UNIT_NONE = 2'd0;
    localparam logic [1:0] UNIT_MM   = 2'd1;
    localparam logic [1:0] UNIT_CM   = 2'd2;
    localparam logic [1:0] UNIT_M    = 2'd3;

    // byte classes handed from front to back
    localparam logic [1:0] CLS_TOKEN = 2'd0;
    localparam logic [1:0] CLS_SEP   = 2'd1;
    localparam logic [1:0] CLS_ZERO  = 2'd2;
    localparam logic [1:0] CLS_EOL   = 2'd3;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_EQ = 8'h3D;
    localparam logic [7:0] CH_CO = 8'h3A;

    typedef struct packed {
        logic [1:0] cls;
        logic       ovf;
        logic [7:0] ch;
    } dlp_req_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [32:0] value;
        logic [1:0]  unit;
    } dlp_num_t;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        upcase = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [7:0] key_char(input logic [1:0] k, input logic [3:0] p);
        logic [63:0] s;
        s = 64'h0;
        case (k)
            2'd0: s = {"DIST", 32'h0};
            2'd1: s = "DISTANCE";
            2'd2: s = {"RANGE", 24'h0};
            default: s = {"DIST_MM", 8'h0};
        endcase
        key_char = s[63 - 8*p[2:0] -: 8];
    endfunction

    function automatic logic [3:0] key_len(input logic [1:0] k);
        case (k)
            2'd0: key_len = 4'd4;
            2'd1: key_len = 4'd8;
            2'd2: key_len = 4'd5;
            default: key_len = 4'd7;
        endcase
    endfunction

endpackage
`default_nettype wire

[rtl/dlp_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dlp_front
// accepts bytes, tracks line length and classifies each byte it passes on
// ----------------------------------------------------------------------------
module dlp_front #(
    parameter int LINE_CAPACITY = dlp_pkg::LINE_CAPACITY_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [7:0]       in_byte,
    output logic                  in_stall,
    output logic                  req_valid,
    output dlp_pkg::dlp_req_t     req,
    input  wire logic             req_stall
);
    localparam int LW = $clog2(LINE_CAPACITY);

    logic [LW-1:0] len_reg, len_next;
    logic          ovf_reg, ovf_next;
    logic          ended_reg, ended_next;
    logic          fire;

    assign in_stall = req_stall;
    assign fire     = in_valid && !req_stall;

    always_comb
    begin
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        ended_next = ended_reg;
        req_valid  = 1'b0;
        req.cls    = dlp_pkg::CLS_TOKEN;
        req.ovf    = ovf_reg;
        req.ch     = in_byte;
        if (fire && in_byte != dlp_pkg::CH_CR)
        begin
            if (in_byte == dlp_pkg::CH_LF)
            begin
                req_valid  = 1'b1;
                req.cls    = dlp_pkg::CLS_EOL;
                len_next   = '0;
                ovf_next   = 1'b0;
                ended_next = 1'b0;
            end
            else if (!ovf_reg)
            begin
                if ({1'b0, len_reg} >= (LW+1)'(LINE_CAPACITY - 1))
                begin
                    len_next = '0;
                    ovf_next = 1'b1;
                end
                else
                begin
                    len_next = len_reg + 1'b1;
                    if (!ended_reg)
                    begin
                        req_valid = 1'b1;
                        if (in_byte == 8'h00)
                        begin
                            req.cls    = dlp_pkg::CLS_ZERO;
                            ended_next = 1'b1;
                        end
                        else if (in_byte == 8'h2C || in_byte == 8'h3B ||
                                 in_byte == 8'h09 || in_byte == 8'h20)
                            req.cls = dlp_pkg::CLS_SEP;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            ended_reg <= 1'b0;
        end
        else
        begin
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            ended_reg <= ended_next;
        end
    end

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, len_reg} < (LW+1)'(LINE_CAPACITY)) else $error("length overrun");
    a_ovf_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && ovf_reg |-> req.cls == dlp_pkg::CLS_EOL) else $error("overflow leak");
    a_ended_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && ended_reg |-> req.cls == dlp_pkg::CLS_EOL) else $error("ended leak");
`endif
endmodule
`default_nettype wire

[rtl/dlp_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dlp_fifo
// two-entry request queue between front and back
// ----------------------------------------------------------------------------
module dlp_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_valid,
    input  wire dlp_pkg::dlp_req_t wr_data,
    output logic                  wr_stall,
    output logic                  rd_valid,
    output dlp_pkg::dlp_req_t     rd_data,
    input  wire logic             rd_stall
);
    dlp_pkg::dlp_req_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_stall = cnt_reg == 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && !wr_stall;
    assign rd = rd_valid && !rd_stall;

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
                wp_reg <= !wp_reg;
            if (rd)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

`ifndef SYNTHESIS
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2) else $error("queue count");
    a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wp_reg == rp_reg) else $error("queue ptr");
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 && !rd |=> cnt_reg == 2'd2) else $error("queue lost");
`endif
endmodule
`default_nettype wire

[rtl/dlp_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dlp_back
// token scanners, key matchers and result register
// ----------------------------------------------------------------------------
module dlp_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire dlp_pkg::dlp_req_t req,
    output logic                   req_stall,
    output logic                   out_valid,
    output logic                   distance_found,
    output logic [31:0]            length_mm,
    input  wire logic              out_stall
);
    localparam logic [32:0] SAT = 33'h1_0000_0000;

    dlp_pkg::dlp_num_t num_reg [3];
    dlp_pkg::dlp_num_t num_next [3];
    logic       ne_reg, ne_next, eq_reg, eq_next, co_reg, co_next;
    logic [3:0] km_reg [2];
    logic [3:0] km_next [2];
    logic [3:0] kp_reg [2];
    logic [3:0] kp_next [2];
    logic       ff_reg, ff_next;
    logic [31:0] fd_reg, fd_next;
    logic       ov_reg, of_reg;
    logic [31:0] od_reg;
    logic       take, finish, clear, win;
    logic [1:0] h;
    logic       need, ok;
    logic [1:0] unit;
    logic [32:0] val;
    logic [42:0] prod;
    logic [7:0] u;

    assign req_stall = ov_reg && out_stall;
    assign take      = req_valid && !req_stall;
    assign out_valid = ov_reg;
    assign distance_found = of_reg;
    assign length_mm      = od_reg;
    assign u = dlp_pkg::upcase(req.ch);

    function automatic dlp_pkg::dlp_num_t nfeed(input dlp_pkg::dlp_num_t n,
                                               input logic [7:0] c);
        dlp_pkg::dlp_num_t r;
        logic [7:0]  uc;
        logic [36:0] v;
        r  = n;
        uc = dlp_pkg::upcase(c);
        v  = {n.value, 3'b0} + {2'b0, n.value, 1'b0} + {29'b0, c - 8'h30};
        unique case (n.phase)
            dlp_pkg::PH_LEAD:
                if (dlp_pkg::is_digit(c))
                begin
                    r.value = {25'b0, c - 8'h30};
                    r.phase = dlp_pkg::PH_DIGITS;
                end
                else if (!dlp_pkg::is_ws(c))
                    r.phase = dlp_pkg::PH_FAIL;
            dlp_pkg::PH_DIGITS, dlp_pkg::PH_GAP:
                if (n.phase == dlp_pkg::PH_DIGITS && dlp_pkg::is_digit(c))
                    r.value = (v > {4'b0, SAT}) ? SAT : v[32:0];
                else if (dlp_pkg::is_ws(c)) r.phase = dlp_pkg::PH_GAP;
                else if (uc == 8'h43) r.phase = dlp_pkg::PH_C;
                else if (uc == 8'h4D) r.phase = dlp_pkg::PH_M;
                else r.phase = dlp_pkg::PH_FAIL;
            dlp_pkg::PH_C:
                if (uc == 8'h4D)
                begin
                    r.unit = dlp_pkg::UNIT_CM;
                    r.phase = dlp_pkg::PH_TAIL;
                end
                else r.phase = dlp_pkg::PH_FAIL;
            dlp_pkg::PH_M:
                if (uc == 8'h4D)
                begin
                    r.unit = dlp_pkg::UNIT_MM;
                    r.phase = dlp_pkg::PH_TAIL;
                end
                else if (dlp_pkg::is_ws(c))
                begin
                    r.unit = dlp_pkg::UNIT_M;
                    r.phase = dlp_pkg::PH_TAIL;
                end
                else r.phase = dlp_pkg::PH_FAIL;
            dlp_pkg::PH_TAIL:
                if (!dlp_pkg::is_ws(c)) r.phase = dlp_pkg::PH_FAIL;
            default: r.phase = dlp_pkg::PH_FAIL;
        endcase
        return r;
    endfunction

    function automatic logic key_hit(input logic [3:0] m, input logic [3:0] p);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < 4; k++)
            if (m[k] && p == dlp_pkg::key_len(2'(k)))
                hit = 1'b1;
        return hit;
    endfunction

    always_comb
    begin
        h = 2'd0;
        need = 1'b1;
        if (eq_reg)
        begin
            h = 2'd1;
            need = !key_hit(km_reg[0], kp_reg[0]);
        end
        else if (co_reg)
        begin
            h = 2'd2;
            need = !key_hit(km_reg[1], kp_reg[1]);
        end
        ok = 1'b1;
        unit = dlp_pkg::UNIT_NONE;
        case (num_reg[h].phase)
            dlp_pkg::PH_DIGITS, dlp_pkg::PH_GAP: unit = dlp_pkg::UNIT_NONE;
            dlp_pkg::PH_M: unit = dlp_pkg::UNIT_M;
            dlp_pkg::PH_TAIL: unit = num_reg[h].unit;
            default: ok = 1'b0;
        endcase
        val = num_reg[h].value;
        case (unit)
            dlp_pkg::UNIT_CM: prod = {10'b0, val} * 43'd10;
            dlp_pkg::UNIT_M:  prod = {10'b0, val} * 43'd1000;
            default:          prod = {10'b0, val};
        endcase
    end

    always_comb
    begin
        finish = take && req.cls != dlp_pkg::CLS_TOKEN && !req.ovf;
        clear  = take && req.cls != dlp_pkg::CLS_TOKEN;
        win    = finish && ne_reg && ok && !(need && unit == dlp_pkg::UNIT_NONE) &&
                 prod[42:32] == 11'd0 && !ff_reg;
        ff_next = ff_reg;
        fd_next = fd_reg;
        ne_next = ne_reg;
        eq_next = eq_reg;
        co_next = co_reg;
        for (int i = 0; i < 3; i++)
            num_next[i] = num_reg[i];
        for (int j = 0; j < 2; j++)
        begin
            km_next[j] = km_reg[j];
            kp_next[j] = kp_reg[j];
        end
        if (win)
        begin
            ff_next = 1'b1;
            fd_next = prod[31:0];
        end
        if (take && req.cls == dlp_pkg::CLS_TOKEN)
        begin
            ne_next = 1'b1;
            num_next[0] = nfeed(num_reg[0], req.ch);
            if (eq_reg) num_next[1] = nfeed(num_reg[1], req.ch);
            else if (req.ch == dlp_pkg::CH_EQ) eq_next = 1'b1;
            if (co_reg) num_next[2] = nfeed(num_reg[2], req.ch);
            else if (req.ch == dlp_pkg::CH_CO) co_next = 1'b1;
            for (int j = 0; j < 2; j++)
                if ((j == 0 && !eq_reg && req.ch != dlp_pkg::CH_EQ) ||
                    (j == 1 && !co_reg && req.ch != dlp_pkg::CH_CO))
                begin
                    for (int k = 0; k < 4; k++)
                        if (kp_reg[j] >= dlp_pkg::key_len(2'(k)) ||
                            dlp_pkg::key_char(2'(k), kp_reg[j]) != u)
                            km_next[j][k] = 1'b0;
                    if (kp_reg[j] != 4'd15)
                        kp_next[j] = kp_reg[j] + 4'd1;
                end
        end
        if (clear)
        begin
            ne_next = 1'b0;
            eq_next = 1'b0;
            co_next = 1'b0;
            for (int i = 0; i < 3; i++)
                num_next[i] = '{dlp_pkg::PH_LEAD, 33'd0, dlp_pkg::UNIT_NONE};
            for (int j = 0; j < 2; j++)
            begin
                km_next[j] = 4'hF;
                kp_next[j] = 4'd0;
            end
        end
        if (take && req.cls == dlp_pkg::CLS_EOL)
        begin
            ff_next = 1'b0;
            fd_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ff_reg <= 1'b0;
            fd_reg <= '0;
            ne_reg <= 1'b0;
            eq_reg <= 1'b0;
            co_reg <= 1'b0;
            ov_reg <= 1'b0;
            of_reg <= 1'b0;
            od_reg <= '0;
            for (int i = 0; i < 3; i++)
                num_reg[i] <= '{dlp_pkg::PH_LEAD, 33'd0, dlp_pkg::UNIT_NONE};
            for (int j = 0; j < 2; j++)
            begin
                km_reg[j] <= 4'hF;
                kp_reg[j] <= 4'd0;
            end
        end
        else
        begin
            ff_reg <= ff_next;
            fd_reg <= fd_next;
            ne_reg <= ne_next;
            eq_reg <= eq_next;
            co_reg <= co_next;
            for (int i = 0; i < 3; i++)
                num_reg[i] <= num_next[i];
            for (int j = 0; j < 2; j++)
            begin
                km_reg[j] <= km_next[j];
                kp_reg[j] <= kp_next[j];
            end
            if (take && req.cls == dlp_pkg::CLS_EOL)
            begin
                ov_reg <= 1'b1;
                of_reg <= (ff_reg || win) && !req.ovf;
                od_reg <= ((ff_reg || win) && !req.ovf) ?
                          (ff_reg ? fd_reg : prod[31:0]) : 32'd0;
            end
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !distance_found |-> length_mm == 32'd0) else $error("stray value");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid) else $error("result dropped");
    a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && req.cls == dlp_pkg::CLS_EOL |=> !ff_reg && !ne_reg) else $error("no clear");
`endif
endmodule
`default_nettype wire

[rtl/distance_line_parser_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// distance_line_parser_top
// streaming text line parser giving a distance in millimetres per line
// ----------------------------------------------------------------------------
// path: a newline reaches result valid through the queue write and then the back register
// throughput: one byte per cycle while the request queue is not full (in_stall low)
// reset: asynchronous, clears line, token and found state and empties the queue
module distance_line_parser_top #(
    parameter int LINE_CAPACITY = dlp_pkg::LINE_CAPACITY_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             distance_found,
    output logic [31:0]      length_mm
);
    logic              f_valid, f_stall, b_valid, b_stall;
    dlp_pkg::dlp_req_t f_req, b_req;

    dlp_front #(.LINE_CAPACITY(LINE_CAPACITY)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_byte(rx_byte),
        .in_stall(in_stall), .req_valid(f_valid), .req(f_req), .req_stall(f_stall)
    );

    dlp_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_data(f_req),
        .wr_stall(f_stall), .rd_valid(b_valid), .rd_data(b_req), .rd_stall(b_stall)
    );

    dlp_back u_back (
        .clk(clk), .rst_n(rst_n), .req_valid(b_valid), .req(b_req),
        .req_stall(b_stall), .out_valid(out_valid), .distance_found(distance_found),
        .length_mm(length_mm), .out_stall(out_stall)
    );
endmodule
`default_nettype wire
